FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file fvc_checker.sv.
// Depends on a clock aclk and an active-low reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is low
`define FVC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define FVC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: rtl/core/fvc_pkg.sv
// Types, constants and arithmetic helpers of the formation velocity controller.
// No dependencies.
package fvc_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_OWN_ID    = 3'd0,
        REG_DELTA_T   = 3'd1,
        REG_VEL_GAIN  = 3'd2,
        REG_POS_GAIN  = 3'd3,
        REG_DES_DIST  = 3'd4,
        REG_TIMEOUT   = 3'd5,
        REG_VEL_MAX   = 3'd6,
        REG_VEL_MIN   = 3'd7
    } reg_idx_t;

    localparam logic        ACT_UPDATE = 1'b0;
    localparam logic        ACT_TICK   = 1'b1;

    localparam logic [1:0]  RST_OWN_ID   = 2'd0;
    localparam logic [30:0] RST_DELTA_T  = 31'd32768;
    localparam logic [30:0] RST_VEL_GAIN = 31'd65536;
    localparam logic [30:0] RST_POS_GAIN = 31'd459;
    localparam logic [30:0] RST_DES_DIST = 31'd262144;
    localparam logic [31:0] RST_TIMEOUT  = 32'd500;
    localparam logic signed [31:0] RST_VEL_MAX = 32'sd32768;
    localparam logic signed [31:0] RST_VEL_MIN = -32'sd32768;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         own_id;
        logic [30:0]        delta_t;
        logic [30:0]        vel_gain;
        logic [30:0]        pos_gain;
        logic [30:0]        goal_range;
        logic [31:0]        timeout_ms;
        logic signed [31:0] vel_max;
        logic signed [31:0] vel_min;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic [31:0]        time_ms;
        logic [3:0]         requester_id;
        logic [3:0]         responder_id;
        logic signed [31:0] requester_vel_x;
        logic signed [31:0] requester_vel_y;
        logic signed [31:0] responder_vel_x;
        logic signed [31:0] responder_vel_y;
        logic signed [31:0] relpos_x;
        logic signed [31:0] relpos_y;
        logic [30:0]        range_dist;
    } item_t;

    // One row of the agent table
    typedef struct packed {
        logic [31:0]        stamp;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        span;
    } entry_t;

    typedef struct packed {
        logic signed [31:0] vel_cmd_x;
        logic signed [31:0] vel_cmd_y;
        logic               control_valid;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_UPD0,
        ST_UPD1,
        ST_UPD2,
        ST_UPD3,
        ST_DD,
        ST_OWN_RD,
        ST_OWN_LD,
        ST_PEER_RD,
        ST_PEER_CHK,
        ST_PEER_DIFF,
        ST_PEER_PX,
        ST_PEER_PY,
        ST_PEER_ACC,
        ST_A_V,
        ST_A_P,
        ST_A_SUM,
        ST_A_DT,
        ST_A_VEL,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'(S32_MAX)) begin
            return S32_MAX;
        end else if (v < 64'(S32_MIN)) begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        if (v == S32_MIN) begin
            return S32_MAX;
        end
        return -v;
    endfunction

    function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

FILE: rtl/core/fvc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/core/fvc_regs.sv
// APB-style configuration register file of the formation velocity controller.
// Depends on fvc_pkg.
module fvc_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output fvc_pkg::cfg_t cfg
);
    import fvc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_id     <= RST_OWN_ID;
            cfg_reg.delta_t    <= RST_DELTA_T;
            cfg_reg.vel_gain   <= RST_VEL_GAIN;
            cfg_reg.pos_gain   <= RST_POS_GAIN;
            cfg_reg.goal_range <= RST_DES_DIST;
            cfg_reg.timeout_ms <= RST_TIMEOUT;
            cfg_reg.vel_max    <= RST_VEL_MAX;
            cfg_reg.vel_min    <= RST_VEL_MIN;
        end else if (wr_en) begin
            unique case (idx)
                REG_OWN_ID:   cfg_reg.own_id     <= pwdata[1:0];
                REG_DELTA_T:  cfg_reg.delta_t    <= pwdata[30:0];
                REG_VEL_GAIN: cfg_reg.vel_gain   <= pwdata[30:0];
                REG_POS_GAIN: cfg_reg.pos_gain   <= pwdata[30:0];
                REG_DES_DIST: cfg_reg.goal_range <= pwdata[30:0];
                REG_TIMEOUT:  cfg_reg.timeout_ms <= pwdata;
                REG_VEL_MAX:  cfg_reg.vel_max    <= pwdata;
                REG_VEL_MIN:  cfg_reg.vel_min    <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            REG_OWN_ID:   prdata = {30'd0, cfg_reg.own_id};
            REG_DELTA_T:  prdata = {1'b0, cfg_reg.delta_t};
            REG_VEL_GAIN: prdata = {1'b0, cfg_reg.vel_gain};
            REG_POS_GAIN: prdata = {1'b0, cfg_reg.pos_gain};
            REG_DES_DIST: prdata = {1'b0, cfg_reg.goal_range};
            REG_TIMEOUT:  prdata = cfg_reg.timeout_ms;
            REG_VEL_MAX:  prdata = cfg_reg.vel_max;
            REG_VEL_MIN:  prdata = cfg_reg.vel_min;
            default:      prdata = '0;
        endcase
    end
endmodule

FILE: rtl/core/fvc_engine.sv
// Sequencer and shared-multiplier datapath: table updates and control ticks.
// Depends on fvc_pkg and fvc_ram.
module fvc_engine #(
    parameter int NUM_AGENTS = 3
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  fvc_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  fvc_pkg::item_t in_item,
    input  logic           out_free,
    output logic           res_load,
    output fvc_pkg::res_t  res
);
    import fvc_pkg::*;

    localparam int IDX_W = $clog2(NUM_AGENTS);
    localparam int ENT_W = $bits(entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_AGENTS - 1);

    state_t state_reg, state_next;

    item_t              item_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               axis_reg;
    logic               any_reg;
    logic [31:0]        os_reg;
    logic signed [31:0] selfx_reg, selfy_reg;
    logic signed [31:0] posx_reg, posy_reg;
    logic signed [31:0] diff_reg;
    logic signed [31:0] acc_reg;
    logic signed [63:0] dd_reg, prod_reg, part_reg;
    logic signed [63:0] svx_reg, svy_reg, spx_reg, spy_reg;
    logic signed [63:0] vx_reg, vy_reg;
    logic [NUM_AGENTS-1:0] vld_reg;
    logic               rd_vld_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    entry_t             wr_ent;
    logic [ENT_W-1:0]   ram_rdata;
    entry_t             ent_rd;

    logic               ids_ok, own_ok, rq_own, rs_own, fresh;
    logic [IDX_W-1:0]   own_idx, rq_idx, rs_idx;
    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] self_ax;
    logic signed [63:0] hi, lo;

    // Table memory
    fvc_ram #(
        .WIDTH(ENT_W),
        .DEPTH(NUM_AGENTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(wr_ent),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Rows never written read as zero
    assign ent_rd = rd_vld_reg ? entry_t'(ram_rdata) : '0;

    assign own_ok  = 32'(cfg.own_id) < NUM_AGENTS;
    assign ids_ok  = (32'(item_reg.requester_id) < NUM_AGENTS)
                  && (32'(item_reg.responder_id) < NUM_AGENTS);
    assign rq_own  = item_reg.requester_id == {2'b00, cfg.own_id};
    assign rs_own  = item_reg.responder_id == {2'b00, cfg.own_id};
    assign own_idx = IDX_W'(cfg.own_id);
    assign rq_idx  = item_reg.requester_id[IDX_W-1:0];
    assign rs_idx  = item_reg.responder_id[IDX_W-1:0];
    assign fresh   = (absdiff(os_reg, item_reg.time_ms) < cfg.timeout_ms)
                  && (absdiff(os_reg, ent_rd.stamp) < cfg.timeout_ms);
    assign self_ax = axis_reg ? selfy_reg : selfx_reg;
    assign in_ready = (state_reg == ST_IDLE);

    // Swap limits when given backwards
    assign hi = (cfg.vel_max >= cfg.vel_min) ? 64'(cfg.vel_max) : 64'(cfg.vel_min);
    assign lo = (cfg.vel_max >= cfg.vel_min) ? 64'(cfg.vel_min) : 64'(cfg.vel_max);

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v,
                                                 input logic signed [63:0] h,
                                                 input logic signed [63:0] l);
        logic signed [63:0] r;
        r = v;
        if (r >= h) r = h;
        if (r <= l) r = l;
        return r[31:0];
    endfunction

    assign res.vel_cmd_x     = clamp(vx_reg, hi, lo);
    assign res.vel_cmd_y     = clamp(vy_reg, hi, lo);
    assign res.control_valid = any_reg;

    // Next state, memory port and multiplier operands
    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = own_idx;
        ram_raddr  = idx_reg;
        wr_ent     = '0;
        mul_a      = '0;
        mul_b      = '0;
        res_load   = 1'b0;
        wr_ent.stamp = item_reg.time_ms;
        wr_ent.span  = item_reg.range_dist;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (in_item.action == ACT_TICK) ? ST_DD : ST_UPD0;
                end
            end
            ST_UPD0: begin
                ram_we       = ids_ok && rq_own;
                ram_waddr    = rs_idx;
                wr_ent.vel_x = item_reg.responder_vel_x;
                wr_ent.vel_y = item_reg.responder_vel_y;
                wr_ent.pos_x = item_reg.relpos_x;
                wr_ent.pos_y = item_reg.relpos_y;
                state_next   = ST_UPD1;
            end
            ST_UPD1: begin
                ram_we       = ids_ok && rq_own;
                wr_ent.vel_x = item_reg.requester_vel_x;
                wr_ent.vel_y = item_reg.requester_vel_y;
                state_next   = ST_UPD2;
            end
            ST_UPD2: begin
                ram_we       = ids_ok && rs_own;
                ram_waddr    = rq_idx;
                wr_ent.vel_x = item_reg.requester_vel_x;
                wr_ent.vel_y = item_reg.requester_vel_y;
                wr_ent.pos_x = neg_sat(item_reg.relpos_x);
                wr_ent.pos_y = neg_sat(item_reg.relpos_y);
                state_next   = ST_UPD3;
            end
            ST_UPD3: begin
                ram_we       = ids_ok && rs_own;
                wr_ent.vel_x = item_reg.responder_vel_x;
                wr_ent.vel_y = item_reg.responder_vel_y;
                state_next   = ST_IDLE;
            end
            ST_DD: begin
                mul_a      = {1'b0, cfg.goal_range};
                mul_b      = {1'b0, cfg.goal_range};
                state_next = own_ok ? ST_OWN_RD : ST_OUT;
            end
            ST_OWN_RD: begin
                ram_raddr  = own_idx;
                state_next = ST_OWN_LD;
            end
            ST_OWN_LD: state_next = ST_PEER_RD;
            ST_PEER_RD: begin
                if (idx_reg == own_idx) begin
                    state_next = (idx_reg == LAST_IDX) ? ST_A_V : ST_PEER_RD;
                end else begin
                    state_next = ST_PEER_CHK;
                end
            end
            ST_PEER_CHK: begin
                mul_a = {1'b0, ent_rd.span};
                mul_b = {1'b0, ent_rd.span};
                if (fresh) begin
                    state_next = ST_PEER_DIFF;
                end else begin
                    state_next = (idx_reg == LAST_IDX) ? ST_A_V : ST_PEER_RD;
                end
            end
            ST_PEER_DIFF: state_next = ST_PEER_PX;
            ST_PEER_PX: begin
                mul_a      = diff_reg;
                mul_b      = posx_reg;
                state_next = ST_PEER_PY;
            end
            ST_PEER_PY: begin
                mul_a      = diff_reg;
                mul_b      = posy_reg;
                state_next = ST_PEER_ACC;
            end
            ST_PEER_ACC: begin
                state_next = (idx_reg == LAST_IDX) ? ST_A_V : ST_PEER_RD;
            end
            ST_A_V: begin
                mul_a      = {1'b0, cfg.vel_gain};
                mul_b      = sat32(axis_reg ? svy_reg : svx_reg);
                state_next = any_reg ? ST_A_P : ST_OUT;
            end
            ST_A_P: begin
                mul_a      = {1'b0, cfg.pos_gain};
                mul_b      = sat32(axis_reg ? spy_reg : spx_reg);
                state_next = ST_A_SUM;
            end
            ST_A_SUM: state_next = ST_A_DT;
            ST_A_DT: begin
                mul_a      = acc_reg;
                mul_b      = {1'b0, cfg.delta_t};
                state_next = ST_A_VEL;
            end
            ST_A_VEL: state_next = axis_reg ? ST_OUT : ST_A_V;
            ST_OUT: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vld_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (ram_we) begin
                vld_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        prod_reg   <= mul_a * mul_b;
        rd_vld_reg <= vld_reg[ram_raddr];
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_reg <= in_item;
                end
            end
            ST_DD: begin
                idx_reg  <= '0;
                axis_reg <= 1'b0;
                any_reg  <= 1'b0;
                svx_reg  <= '0;
                svy_reg  <= '0;
                spx_reg  <= '0;
                spy_reg  <= '0;
                vx_reg   <= '0;
                vy_reg   <= '0;
            end
            ST_OWN_RD: dd_reg <= prod_reg;
            ST_OWN_LD: begin
                os_reg    <= ent_rd.stamp;
                selfx_reg <= ent_rd.vel_x;
                selfy_reg <= ent_rd.vel_y;
            end
            ST_PEER_RD: begin
                if (idx_reg == own_idx) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_PEER_CHK: begin
                if (fresh) begin
                    any_reg  <= 1'b1;
                    svx_reg  <= svx_reg + 64'(ent_rd.vel_x) - 64'(selfx_reg);
                    svy_reg  <= svy_reg + 64'(ent_rd.vel_y) - 64'(selfy_reg);
                    posx_reg <= ent_rd.pos_x;
                    posy_reg <= ent_rd.pos_y;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_PEER_DIFF: diff_reg <= sat32((prod_reg - dd_reg) >>> 16);
            ST_PEER_PY:   spx_reg  <= spx_reg + (prod_reg >>> 16);
            ST_PEER_ACC: begin
                spy_reg <= spy_reg + (prod_reg >>> 16);
                idx_reg <= idx_reg + 1'b1;
            end
            ST_A_SUM: begin
                part_reg <= prod_reg >>> 16;
            end
            ST_A_DT: ;
            ST_A_VEL: begin
                if (axis_reg) begin
                    vy_reg <= 64'(self_ax) + (prod_reg >>> 16);
                end else begin
                    vx_reg <= 64'(self_ax) + (prod_reg >>> 16);
                end
                axis_reg <= 1'b1;
            end
            default: ;
        endcase
        // Gain terms: velocity part lands in the cycle before the position part
        if (state_reg == ST_A_P) begin
            part_reg <= prod_reg >>> 16;
        end
        if (state_reg == ST_A_SUM) begin
            acc_reg <= sat32(part_reg + (prod_reg >>> 15));
        end
    end
endmodule

FILE: rtl/core/formation_velocity_controller_top.sv
// Top level of the formation velocity controller: ports, registers, result stage.
// Depends on fvc_pkg, fvc_regs and fvc_engine.
//
// Accepts one request at a time. A ranging update uses four table write slots.
// A control tick walks the agent table in one memory, one read per peer,
// through one shared 32x32 multiplier: setup, this agent's own row, a
// freshness check per peer plus the distance and position products per
// fresh peer, the gain and integration steps when any peer is fresh, and
// the hand-off of the result once the output register is free. A finished
// result waits in the output register while the next request is taken.
// The table resets to zero through per-row valid bits.
module formation_velocity_controller_top #(
    parameter int NUM_AGENTS = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [31:0]        s_time_ms,
    input  logic [3:0]         s_requester_id,
    input  logic [3:0]         s_responder_id,
    input  logic signed [31:0] s_requester_vel_x,
    input  logic signed [31:0] s_requester_vel_y,
    input  logic signed [31:0] s_responder_vel_x,
    input  logic signed [31:0] s_responder_vel_y,
    input  logic signed [31:0] s_relpos_x,
    input  logic signed [31:0] s_relpos_y,
    input  logic [30:0]        s_range_dist,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_vel_cmd_x,
    output logic signed [31:0] m_vel_cmd_y,
    output logic               m_control_valid
);
    import fvc_pkg::*;

    cfg_t  cfg;
    item_t item;
    res_t  res, res_reg;
    logic  res_load;
    logic  m_valid_reg;

    fvc_regs u_regs (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    // Pack the request fields
    assign item.action          = s_action;
    assign item.time_ms         = s_time_ms;
    assign item.requester_id    = s_requester_id;
    assign item.responder_id    = s_responder_id;
    assign item.requester_vel_x = s_requester_vel_x;
    assign item.requester_vel_y = s_requester_vel_y;
    assign item.responder_vel_x = s_responder_vel_x;
    assign item.responder_vel_y = s_responder_vel_y;
    assign item.relpos_x        = s_relpos_x;
    assign item.relpos_y        = s_relpos_y;
    assign item.range_dist      = s_range_dist;

    fvc_engine #(
        .NUM_AGENTS(NUM_AGENTS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_valid(s_valid),
        .in_ready(s_ready),
        .in_item (item),
        .out_free(!m_valid_reg || m_ready),
        .res_load(res_load),
        .res     (res)
    );

    // Output register: load a result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_vel_cmd_x     = res_reg.vel_cmd_x;
    assign m_vel_cmd_y     = res_reg.vel_cmd_y;
    assign m_control_valid = res_reg.control_valid;
endmodule

FILE: rtl/core/fvc_checker.sv
// Port-level checks of the formation velocity controller, bound to the top.
// Depends on assert_macros.svh.
module fvc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_vel_cmd_x,
    input logic [31:0] m_vel_cmd_y,
    input logic        m_control_valid
);
`include "assert_macros.svh"

    // A stalled result holds its value
    `FVC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_vel_cmd_x) && $stable(m_vel_cmd_y), "stalled result changed")

    // A ranging update never yields a result
    `FVC_ASSERT(a_upd_silent, s_valid && s_ready && !s_action && !m_valid |=> !m_valid, "result after ranging update")

    // Without a fresh peer both axes give the same clamped zero
    `FVC_ASSERT(a_idle_cmd, m_valid && !m_control_valid |-> m_vel_cmd_x == m_vel_cmd_y, "axes differ without fresh peer")

    // The register port never waits
    `FVC_ASSERT_ALWAYS(a_pready, pready == 1'b1, "pready low")
endmodule

bind formation_velocity_controller_top fvc_checker u_fvc_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench of formation_velocity_controller_top: directed table, then random traffic.
// Depends on fvc_pkg and the RTL top level; predicts results with its own table model.
`timescale 1ns / 100ps

module testbench;
    import fvc_pkg::*;

    localparam int N_AGENTS    = 3;
    localparam int LIMIT_CYCLES = 400000;

    logic               aclk;
    logic               aresetn;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid, s_ready;
    logic               s_action;
    logic [31:0]        s_time_ms;
    logic [3:0]         s_requester_id, s_responder_id;
    logic signed [31:0] s_requester_vel_x, s_requester_vel_y;
    logic signed [31:0] s_responder_vel_x, s_responder_vel_y;
    logic signed [31:0] s_relpos_x, s_relpos_y;
    logic [30:0]        s_range_dist;
    logic               m_valid, m_ready;
    logic signed [31:0] m_vel_cmd_x, m_vel_cmd_y;
    logic               m_control_valid;

    formation_velocity_controller_top #(.NUM_AGENTS(N_AGENTS)) uut (.*);

    // Predictor state
    cfg_t   cfg_q;
    entry_t agent_tab [N_AGENTS];
    res_t   cmd_queue [$];

    int  errors;
    int  n_ticks, n_updates, n_results, n_fresh;
    int  cycle_cnt;
    bit  quiet_mode;
    int  hold_off;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [63:0] shr(input logic signed [63:0] v, input int n);
        return v >>> n;
    endfunction

    function automatic logic signed [63:0] sat_s32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [31:0] negate_sat(input logic signed [31:0] v);
        return 32'(sat_s32(-64'(v)));
    endfunction

    function automatic logic [31:0] stamp_gap(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic void write_entry(int idx, logic [31:0] st, logic signed [31:0] vx,
                                        logic signed [31:0] vy, logic signed [31:0] px,
                                        logic signed [31:0] py, logic [30:0] d);
        if (idx >= N_AGENTS) return;
        agent_tab[idx] = '{st, vx, vy, px, py, d};
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < N_AGENTS; i++) write_entry(i, 0, 0, 0, 0, 0, 0);
    endfunction

    function automatic logic signed [63:0] clamp_cmd(input logic signed [63:0] v);
        logic signed [63:0] hi, lo;
        hi = (cfg_q.vel_max >= cfg_q.vel_min) ? 64'(cfg_q.vel_max) : 64'(cfg_q.vel_min);
        lo = (cfg_q.vel_max >= cfg_q.vel_min) ? 64'(cfg_q.vel_min) : 64'(cfg_q.vel_max);
        if (v >= hi) v = hi;
        if (v <= lo) v = lo;
        return v;
    endfunction

    // Apply one request to the table model; return 1 with a command for ticks
    function automatic bit predict_command(input item_t it, output res_t cmd);
        logic signed [63:0] sv_x, sv_y, sp_x, sp_y, vx, vy, selfx, selfy, dd, peer_span, diff;
        logic signed [63:0] ax, ay;
        logic [31:0] own_st;
        bit fresh;
        int me;
        me = cfg_q.own_id;
        if (it.action == ACT_UPDATE) begin
            if (it.requester_id >= N_AGENTS || it.responder_id >= N_AGENTS) return 0;
            if (it.requester_id == me) begin
                write_entry(it.responder_id, it.time_ms, it.responder_vel_x,
                            it.responder_vel_y, it.relpos_x, it.relpos_y, it.range_dist);
                write_entry(me, it.time_ms, it.requester_vel_x, it.requester_vel_y,
                            0, 0, it.range_dist);
            end
            if (it.responder_id == me) begin
                write_entry(it.requester_id, it.time_ms, it.requester_vel_x,
                            it.requester_vel_y, negate_sat(it.relpos_x),
                            negate_sat(it.relpos_y), it.range_dist);
                write_entry(me, it.time_ms, it.responder_vel_x, it.responder_vel_y,
                            0, 0, it.range_dist);
            end
            return 0;
        end
        fresh = 0;
        sv_x = 0; sv_y = 0; sp_x = 0; sp_y = 0; vx = 0; vy = 0;
        if (me < N_AGENTS) begin
            own_st = agent_tab[me].stamp;
            selfx = agent_tab[me].vel_x;
            selfy = agent_tab[me].vel_y;
            dd = 64'(cfg_q.goal_range) * 64'(cfg_q.goal_range);
            for (int i = 0; i < N_AGENTS; i++) begin
                if (i == me) continue;
                if (stamp_gap(own_st, it.time_ms) >= cfg_q.timeout_ms ||
                    stamp_gap(own_st, agent_tab[i].stamp) >= cfg_q.timeout_ms) continue;
                sv_x += 64'(agent_tab[i].vel_x) - selfx;
                sv_y += 64'(agent_tab[i].vel_y) - selfy;
                peer_span = 64'(agent_tab[i].span);
                diff = sat_s32(shr(peer_span * peer_span - dd, 16));
                sp_x += shr(diff * 64'(agent_tab[i].pos_x), 16);
                sp_y += shr(diff * 64'(agent_tab[i].pos_y), 16);
                fresh = 1;
            end
            if (fresh) begin
                ax = sat_s32(shr(64'(cfg_q.vel_gain) * sat_s32(sv_x), 16) +
                             shr(64'(cfg_q.pos_gain) * sat_s32(sp_x), 15));
                ay = sat_s32(shr(64'(cfg_q.vel_gain) * sat_s32(sv_y), 16) +
                             shr(64'(cfg_q.pos_gain) * sat_s32(sp_y), 15));
                vx = selfx + shr(ax * 64'(cfg_q.delta_t), 16);
                vy = selfy + shr(ay * 64'(cfg_q.delta_t), 16);
            end
        end
        cmd.vel_cmd_x = 32'(clamp_cmd(vx));
        cmd.vel_cmd_y = 32'(clamp_cmd(vy));
        cmd.control_valid = fresh;
        return 1;
    endfunction

    // Register write over the APB port, mirrored in the predictor
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OWN_ID:   cfg_q.own_id = val[1:0];
            REG_DELTA_T:  cfg_q.delta_t = val[30:0];
            REG_VEL_GAIN: cfg_q.vel_gain = val[30:0];
            REG_POS_GAIN: cfg_q.pos_gain = val[30:0];
            REG_DES_DIST: cfg_q.goal_range = val[30:0];
            REG_TIMEOUT:  cfg_q.timeout_ms = val;
            REG_VEL_MAX:  cfg_q.vel_max = val;
            REG_VEL_MIN:  cfg_q.vel_min = val;
            default: ;
        endcase
    endtask

    // Send one request; returns once it is accepted
    task automatic send_request(input item_t it);
        res_t cmd;
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_action          <= it.action;
        s_time_ms         <= it.time_ms;
        s_requester_id    <= it.requester_id;
        s_responder_id    <= it.responder_id;
        s_requester_vel_x <= it.requester_vel_x;
        s_requester_vel_y <= it.requester_vel_y;
        s_responder_vel_x <= it.responder_vel_x;
        s_responder_vel_y <= it.responder_vel_y;
        s_relpos_x        <= it.relpos_x;
        s_relpos_y        <= it.relpos_y;
        s_range_dist      <= it.range_dist;
        do @(posedge aclk); while (!s_ready);
        if (predict_command(it, cmd)) begin
            cmd_queue.push_back(cmd);
            n_ticks++;
            if (cmd.control_valid) n_fresh++;
        end else begin
            n_updates++;
        end
    endtask

    task automatic drain_to_idle();
        s_valid <= 1'b0;
        while (cmd_queue.size() != 0) @(posedge aclk);
        // an update with no result may still be in flight
        repeat (40) @(posedge aclk);
    endtask

    // Result receiver with random stalls and one long hold-off
    initial begin
        m_ready = 1'b0;
        hold_off = 0;
        @(posedge aresetn);
        forever begin
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off--;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                hold_off = $urandom_range(1, 14) - 1;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (cmd_queue.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d v=%0b", $time,
                         m_vel_cmd_x, m_vel_cmd_y, m_control_valid);
                errors++;
            end else begin
                want = cmd_queue.pop_front();
                if (m_vel_cmd_x !== want.vel_cmd_x) begin
                    $display("%0t: vel_cmd_x expected %0d actual %0d", $time,
                             want.vel_cmd_x, m_vel_cmd_x);
                    errors++;
                end
                if (m_vel_cmd_y !== want.vel_cmd_y) begin
                    $display("%0t: vel_cmd_y expected %0d actual %0d", $time,
                             want.vel_cmd_y, m_vel_cmd_y);
                    errors++;
                end
                if (m_control_valid !== want.control_valid) begin
                    $display("%0t: control_valid expected %0b actual %0b", $time,
                             want.control_valid, m_control_valid);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_s32();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $urandom;
            default: return $signed(32'($urandom_range(0, 262144))) - 32'sd131072;
        endcase
    endfunction

    // Mostly well-formed ranging traffic around own_id, with fresh stamps
    function automatic item_t rand_request(input logic [31:0] now);
        item_t it;
        it.action = ($urandom_range(0, 3) == 0) ? ACT_TICK : ACT_UPDATE;
        it.time_ms = ($urandom_range(0, 15) == 0) ? $urandom : now + $urandom_range(0, 300);
        it.requester_id = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        it.responder_id = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 1)) it.requester_id = cfg_q.own_id;
            else it.responder_id = cfg_q.own_id;
        end
        it.requester_vel_x = rand_s32();
        it.requester_vel_y = rand_s32();
        it.responder_vel_x = rand_s32();
        it.responder_vel_y = rand_s32();
        it.relpos_x = rand_s32();
        it.relpos_y = rand_s32();
        it.range_dist = ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                     : 31'($urandom_range(0, 655360));
        return it;
    endfunction

    typedef struct {
        item_t it;
        bit    has_check;
        res_t  check;
    } stim_row_t;

    stim_row_t dir_rows [$];

    function automatic item_t mk(input logic act, input logic [31:0] t, input logic [3:0] rq,
                                 input logic [3:0] rs, input logic signed [31:0] v,
                                 input logic signed [31:0] p, input logic [30:0] d);
        item_t it;
        it = '{act, t, rq, rs, v, -v, ~v, v >>> 1, p, -p, d};
        return it;
    endfunction

    initial begin
        item_t it;
        res_t  got;
        logic [31:0] now;
        errors = 0; n_ticks = 0; n_updates = 0; n_results = 0; n_fresh = 0;
        cycle_cnt = 0;
        quiet_mode = 0;
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_valid = 0; s_action = 0; s_time_ms = 0; s_requester_id = 0; s_responder_id = 0;
        s_requester_vel_x = 0; s_requester_vel_y = 0; s_responder_vel_x = 0;
        s_responder_vel_y = 0; s_relpos_x = 0; s_relpos_y = 0; s_range_dist = 0;
        cfg_q = '{RST_OWN_ID, RST_DELTA_T, RST_VEL_GAIN, RST_POS_GAIN, RST_DES_DIST,
                  RST_TIMEOUT, RST_VEL_MAX, RST_VEL_MIN};
        reset_table();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: tick after reset sees all-zero peers as fresh, with zero terms
        dir_rows.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0, 0), 1, '{32'sd0, 32'sd0, 1'b1}});
        dir_rows.push_back('{mk(ACT_UPDATE, 10, 0, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF), 0, '0});
        dir_rows.push_back('{mk(ACT_UPDATE, 20, 2, 0, 32'sh8000_0000, 32'sh8000_0000, 0), 0, '0});
        dir_rows.push_back('{mk(ACT_TICK, 30, 0, 0, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(ACT_UPDATE, 40, 0, 0, 32'sd65536, 32'sd65536, 31'd262144), 0, '0});
        dir_rows.push_back('{mk(ACT_UPDATE, 45, 1, 2, 32'sd1000, 32'sd5, 31'd5), 0, '0});
        dir_rows.push_back('{mk(ACT_UPDATE, 50, 15, 0, 32'sd9, 32'sd9, 31'd9), 0, '0});
        dir_rows.push_back('{mk(ACT_UPDATE, 50, 0, 3, 32'sd9, 32'sd9, 31'd9), 0, '0});
        dir_rows.push_back('{mk(ACT_TICK, 60, 0, 0, 0, 0, 0), 0, '0});
        // far-off time: every peer stale, clamped zero
        dir_rows.push_back('{mk(ACT_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1,
                             '{32'sd0, 32'sd0, 1'b0}});
        dir_rows.push_back('{mk(ACT_UPDATE, 100, 1, 0, 32'sd40000, 32'sd300000, 31'd400000), 0, '0});
        dir_rows.push_back('{mk(ACT_TICK, 120, 0, 0, 0, 0, 0), 0, '0});
        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].it);
            if (dir_rows[k].has_check) begin
                got = cmd_queue[$];
                if (got !== dir_rows[k].check) begin
                    $display("%0t: row %0d expected %h actual %h", $time, k,
                             dir_rows[k].check, got);
                    errors++;
                end
            end
        end
        drain_to_idle();

        // Random phases over several register settings, extremes included
        now = 1000;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_OWN_ID, 1); write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
                    write_reg(REG_VEL_MAX, 32'h7FFF_FFFF); write_reg(REG_VEL_MIN, 32'h8000_0000);
                end
                1: begin
                    write_reg(REG_OWN_ID, 2); write_reg(REG_DELTA_T, 32'h7FFF_FFFF);
                    write_reg(REG_VEL_GAIN, 32'h7FFF_FFFF); write_reg(REG_POS_GAIN, 32'h7FFF_FFFF);
                    write_reg(REG_DES_DIST, 32'h7FFF_FFFF); write_reg(REG_TIMEOUT, 1000);
                end
                2: begin
                    write_reg(REG_OWN_ID, 0); write_reg(REG_DELTA_T, 0);
                    write_reg(REG_VEL_GAIN, 0); write_reg(REG_POS_GAIN, 0);
                    write_reg(REG_DES_DIST, 0); write_reg(REG_TIMEOUT, 0);
                    write_reg(REG_VEL_MAX, 32'hFFFF_0000); write_reg(REG_VEL_MIN, 32'h0002_0000);
                end
                3: begin
                    write_reg(REG_OWN_ID, 3); write_reg(REG_TIMEOUT, 700);
                end
                4: begin
                    write_reg(REG_OWN_ID, 1); write_reg(REG_DELTA_T, $urandom);
                    write_reg(REG_VEL_GAIN, $urandom); write_reg(REG_POS_GAIN, $urandom);
                    write_reg(REG_DES_DIST, $urandom); write_reg(REG_TIMEOUT, $urandom_range(1, 600));
                    write_reg(REG_VEL_MAX, $urandom); write_reg(REG_VEL_MIN, $urandom);
                end
                default: begin
                    write_reg(REG_OWN_ID, $urandom_range(0, 2));
                    write_reg(REG_DELTA_T, RST_DELTA_T); write_reg(REG_VEL_GAIN, RST_VEL_GAIN);
                    write_reg(REG_POS_GAIN, RST_POS_GAIN); write_reg(REG_DES_DIST, RST_DES_DIST);
                    write_reg(REG_TIMEOUT, 2000);
                    write_reg(REG_VEL_MAX, 32'h0010_0000); write_reg(REG_VEL_MIN, 32'hFFF0_0000);
                end
            endcase
            quiet_mode = (ph == 6);
            // long receiver hold-off while requests keep coming
            if (ph == 1) hold_off = 300;
            for (int n = 0; n < 200; n++) begin
                it = rand_request(now);
                now += $urandom_range(0, 40);
                send_request(it);
            end
            drain_to_idle();
        end

        repeat (50) @(posedge aclk);
        $display("Covered %0d ranging updates and %0d ticks (%0d with fresh peers),",
                 n_updates, n_ticks, n_fresh);
        $display("%0d results checked across eight register settings.", n_results);
        if (errors == 0 && cmd_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
